// ===== design/svie_pkg.sv =====
// ----------------------------------------------------------------------------
// svie_pkg: shared definitions of the stack machine executor
// Sizes, opcodes, error codes, sequencer states and the request and response
// structures of the multiply/divide unit.
// ----------------------------------------------------------------------------
package svie_pkg;

    localparam int DATA_DEPTH  = 4096;
    localparam int STACK_DEPTH = 256;

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] OPC_NOP  = 8'd0;
    localparam logic [7:0] OPC_PUSH = 8'd1;
    localparam logic [7:0] OPC_POP  = 8'd2;
    localparam logic [7:0] OPC_JMP  = 8'd3;
    localparam logic [7:0] OPC_JZ   = 8'd4;
    localparam logic [7:0] OPC_CALL = 8'd5;
    localparam logic [7:0] OPC_CZ   = 8'd6;
    localparam logic [7:0] OPC_RET  = 8'd7;
    localparam logic [7:0] OPC_INC  = 8'd8;
    localparam logic [7:0] OPC_DEC  = 8'd9;
    localparam logic [7:0] OPC_ADD  = 8'd10;
    localparam logic [7:0] OPC_SUB  = 8'd11;
    localparam logic [7:0] OPC_MUL  = 8'd12;
    localparam logic [7:0] OPC_DIV  = 8'd13;
    localparam logic [7:0] OPC_MOD  = 8'd14;
    localparam logic [7:0] OPC_GT   = 8'd15;
    localparam logic [7:0] OPC_LT   = 8'd16;
    localparam logic [7:0] OPC_EQ   = 8'd17;
    localparam logic [7:0] OPC_AND  = 8'd18;
    localparam logic [7:0] OPC_OR   = 8'd19;
    localparam logic [7:0] OPC_NOT  = 8'd20;
    localparam logic [7:0] OPC_IN   = 8'd21;
    localparam logic [7:0] OPC_OUT  = 8'd22;
    localparam logic [7:0] OPC_HALT = 8'd23;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_UNDER = 3'd1;
    localparam logic [2:0] ERR_OVER  = 3'd2;
    localparam logic [2:0] ERR_DIV0  = 3'd3;
    localparam logic [2:0] ERR_OPC   = 3'd4;
    localparam logic [2:0] ERR_ADDR  = 3'd5;
    localparam logic [2:0] ERR_IP    = 3'd6;

    localparam logic OP_LOAD = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_ALU
    } t_state;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        want_rem;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_md_rsp;

endpackage

// ===== design/stack_vm_instruction_executor_unit.sv =====
// ----------------------------------------------------------------------------
// stack_vm_instruction_executor_unit: one instruction of a stack machine
// Holds the instruction pointer, data store, operand stack and return stack,
// and executes one load or instruction request at a time.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------
//  request  | i_start, o_busy       | i_op, i_opcode, i_address, i_value
//  result   | o_done (one cycle)    | o_next_ip, o_halted, o_out_valid,
//           |                       | o_out_value, o_error
//  config   | i_cfg_we              | i_cfg_wdata (code length)
//
// A request is taken when i_start is high and o_busy is low. It reads the
// memories in S_READ and executes in S_EXEC; for most instructions the
// result is then registered and shown with o_done. MUL, DIV and MOD pass
// through the shared multiply/divide unit, one bit per cycle, in S_ALU.
// Reset clears the instruction pointer, both stack counts and the code
// length; the memories are not cleared. The receiver cannot stall, so
// o_done is a single pulse.
//
module stack_vm_instruction_executor_unit
    import svie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_op,
    input  logic [7:0]  i_opcode,
    input  logic [15:0] i_address,
    input  logic [31:0] i_value,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_done,
    output logic [15:0] o_next_ip,
    output logic        o_halted,
    output logic        o_out_valid,
    output logic [31:0] o_out_value,
    output logic [2:0]  o_error
);

    t_state r_state, n_state;

    logic [15:0]    r_code_len;
    logic [15:0]    r_ip,   n_ip;
    logic [SCW-1:0] r_ocnt, n_ocnt;
    logic [SCW-1:0] r_rcnt, n_rcnt;

    // Latched request.
    logic        r_op;
    logic [7:0]  r_opc;
    logic [15:0] r_addr;
    logic [31:0] r_val;

    // Registered memory read data.
    logic [31:0] r_dword;
    logic [31:0] r_top;
    logic [31:0] r_nxt;
    logic [15:0] r_ret;

    // Result registers.
    logic        r_done,   n_done;
    logic        r_halted, n_halted;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_ovalue, n_ovalue;
    logic [2:0]  r_err,    n_err;

    logic [31:0] r_data_mem [DATA_DEPTH];
    logic [31:0] r_ostk_mem [STACK_DEPTH];
    logic [15:0] r_rstk_mem [STACK_DEPTH];

    logic           w_dwe, w_swe, w_rwe;
    logic [DAW-1:0] w_didx;
    logic [31:0]    w_dwd, w_swd;
    logic [SAW-1:0] w_sidx;
    logic [SCW-1:0] w_om1, w_om2, w_rm1;
    logic [SAW-1:0] w_top_idx, w_nxt_idx, w_ret_idx, w_rpush_idx, w_opush_idx;
    logic           w_go_alu;
    logic           w_addr_ok;

    t_md_req w_md_req;
    t_md_rsp w_md_rsp;

    svie_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    assign w_om1       = r_ocnt - SCW'(1);
    assign w_om2       = r_ocnt - SCW'(2);
    assign w_rm1       = r_rcnt - SCW'(1);
    assign w_top_idx   = w_om1[SAW-1:0];
    assign w_nxt_idx   = w_om2[SAW-1:0];
    assign w_ret_idx   = w_rm1[SAW-1:0];
    assign w_opush_idx = r_ocnt[SAW-1:0];
    assign w_rpush_idx = r_rcnt[SAW-1:0];
    assign w_didx      = r_addr[DAW-1:0];
    assign w_addr_ok   = {1'b0, r_addr} < 17'(DATA_DEPTH);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = w_go_alu ? S_ALU : S_IDLE;
            end
            S_ALU: begin
                if (w_md_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Execution: errors in order of precedence, then the effects. Any
    // error leaves every piece of state as it was.
    // ------------------------------------------------------------------
    always_comb begin
        logic        use_mem;
        logic [31:0] upd;
        logic        empty, full, rfull, two;

        use_mem = (r_opc == OPC_PUSH) || (r_opc == OPC_POP) ||
                  (((r_opc == OPC_INC) || (r_opc == OPC_DEC) || (r_opc == OPC_NOT)) &&
                   (r_addr != 16'd0));
        empty = (r_ocnt == SCW'(0));
        two   = (r_ocnt >= SCW'(2));
        full  = (r_ocnt >= SCW'(STACK_DEPTH));
        rfull = (r_rcnt >= SCW'(STACK_DEPTH));
        upd   = 32'd0;

        n_ip      = r_ip;
        n_ocnt    = r_ocnt;
        n_rcnt    = r_rcnt;
        n_done    = 1'b0;
        n_halted  = 1'b0;
        n_ovalid  = 1'b0;
        n_ovalue  = 32'd0;
        n_err     = ERR_NONE;
        w_dwe     = 1'b0;
        w_dwd     = r_top;
        w_swe     = 1'b0;
        w_sidx    = w_top_idx;
        w_swd     = 32'd0;
        w_rwe     = 1'b0;
        w_go_alu  = 1'b0;
        w_md_req.start    = 1'b0;
        w_md_req.is_div   = (r_opc != OPC_MUL);
        w_md_req.want_rem = (r_opc == OPC_MOD);
        w_md_req.a        = r_nxt;
        w_md_req.b        = r_top;

        if (r_state == S_EXEC) begin
            n_done = 1'b1;
            if (r_op == OP_LOAD) begin
                if (w_addr_ok) begin
                    w_dwe = 1'b1;
                    w_dwd = r_val;
                end else begin
                    n_err = ERR_ADDR;
                end
            end else if (r_ip >= r_code_len) begin
                n_err = ERR_IP;
            end else if (r_opc > OPC_HALT) begin
                n_err = ERR_OPC;
            end else if (use_mem && !w_addr_ok) begin
                n_err = ERR_ADDR;
            end else begin
                n_ip = r_ip + 16'd1;
                case (r_opc) inside
                    OPC_PUSH, OPC_IN: begin
                        if (full) begin
                            n_err = ERR_OVER;
                        end else begin
                            w_swe  = 1'b1;
                            w_sidx = w_opush_idx;
                            w_swd  = (r_opc == OPC_IN) ? r_val : r_dword;
                            n_ocnt = r_ocnt + SCW'(1);
                        end
                    end
                    OPC_POP: begin
                        if (empty) begin
                            n_err = ERR_UNDER;
                        end else begin
                            w_dwe  = 1'b1;
                            w_dwd  = r_top;
                            n_ocnt = w_om1;
                        end
                    end
                    OPC_JMP: begin
                        n_ip = r_addr;
                    end
                    OPC_JZ, OPC_CZ: begin
                        if (empty) begin
                            n_err = ERR_UNDER;
                        end else if (r_top != 32'd0) begin
                            n_ocnt = w_om1;
                        end else if ((r_opc == OPC_CZ) && rfull) begin
                            n_err = ERR_OVER;
                        end else begin
                            n_ocnt = w_om1;
                            n_ip   = r_addr;
                            if (r_opc == OPC_CZ) begin
                                w_rwe  = 1'b1;
                                n_rcnt = r_rcnt + SCW'(1);
                            end
                        end
                    end
                    OPC_CALL: begin
                        if (rfull) begin
                            n_err = ERR_OVER;
                        end else begin
                            w_rwe  = 1'b1;
                            n_rcnt = r_rcnt + SCW'(1);
                            n_ip   = r_addr;
                        end
                    end
                    OPC_RET: begin
                        if (r_rcnt == SCW'(0)) begin
                            n_err = ERR_UNDER;
                        end else begin
                            n_rcnt = w_rm1;
                            n_ip   = r_ret + 16'd1;
                        end
                    end
                    OPC_INC, OPC_DEC, OPC_NOT: begin
                        if ((r_addr == 16'd0) && empty) begin
                            n_err = ERR_UNDER;
                        end else begin
                            upd = (r_addr != 16'd0) ? r_dword : r_top;
                            if (r_opc == OPC_INC) begin
                                upd = upd + 32'd1;
                            end else if (r_opc == OPC_DEC) begin
                                upd = upd - 32'd1;
                            end else begin
                                upd = {31'd0, (upd == 32'd0)};
                            end
                            if (r_addr != 16'd0) begin
                                w_dwe = 1'b1;
                                w_dwd = upd;
                            end else begin
                                w_swe = 1'b1;
                                w_swd = upd;
                            end
                        end
                    end
                    OPC_OUT: begin
                        if (empty) begin
                            n_err = ERR_UNDER;
                        end else begin
                            n_ocnt   = w_om1;
                            n_ovalid = 1'b1;
                            n_ovalue = r_top;
                        end
                    end
                    OPC_HALT: begin
                        n_halted = 1'b1;
                        n_ip     = r_ip;
                    end
                    OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV, OPC_MOD,
                    OPC_GT, OPC_LT, OPC_EQ, OPC_AND, OPC_OR: begin
                        if (!two) begin
                            n_err = ERR_UNDER;
                        end else if (((r_opc == OPC_DIV) || (r_opc == OPC_MOD)) &&
                                     (r_top == 32'd0)) begin
                            n_err = ERR_DIV0;
                        end else if ((r_opc == OPC_MUL) || (r_opc == OPC_DIV) ||
                                     (r_opc == OPC_MOD)) begin
                            // Result and writeback come from the shared unit.
                            w_md_req.start = 1'b1;
                            w_go_alu       = 1'b1;
                            n_done         = 1'b0;
                            n_ip           = r_ip;
                        end else begin
                            case (r_opc)
                                OPC_ADD: upd = r_nxt + r_top;
                                OPC_SUB: upd = r_nxt - r_top;
                                OPC_GT:  upd = {31'd0, ($signed(r_nxt) > $signed(r_top))};
                                OPC_LT:  upd = {31'd0, ($signed(r_nxt) < $signed(r_top))};
                                OPC_EQ:  upd = {31'd0, (r_nxt == r_top)};
                                OPC_AND: upd = {31'd0, ((r_nxt != 32'd0) && (r_top != 32'd0))};
                                default: upd = {31'd0, ((r_nxt != 32'd0) || (r_top != 32'd0))};
                            endcase
                            w_swe  = 1'b1;
                            w_sidx = w_nxt_idx;
                            w_swd  = upd;
                            n_ocnt = w_om1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (n_err != ERR_NONE) begin
                    n_ip   = r_ip;
                    n_ocnt = r_ocnt;
                    n_rcnt = r_rcnt;
                    w_dwe  = 1'b0;
                    w_swe  = 1'b0;
                    w_rwe  = 1'b0;
                end
            end
        end else if ((r_state == S_ALU) && w_md_rsp.done) begin
            n_done = 1'b1;
            n_ip   = r_ip + 16'd1;
            w_swe  = 1'b1;
            w_sidx = w_nxt_idx;
            w_swd  = w_md_rsp.result;
            n_ocnt = w_om1;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_code_len <= 16'd0;
            r_ip       <= 16'd0;
            r_ocnt     <= '0;
            r_rcnt     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ip    <= n_ip;
            r_ocnt  <= n_ocnt;
            r_rcnt  <= n_rcnt;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_code_len <= i_cfg_wdata;
            end
        end
    end

    // Request latch and result payload.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_op   <= i_op;
            r_opc  <= i_opcode;
            r_addr <= i_address;
            r_val  <= i_value;
        end
        if (n_done) begin
            r_halted <= n_halted;
            r_ovalid <= n_ovalid;
            r_ovalue <= n_ovalue;
            r_err    <= n_err;
        end
    end

    // ------------------------------------------------------------------
    // Memories: one write port each, reads registered during S_READ.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_dwe) begin
            r_data_mem[w_didx] <= w_dwd;
        end
        if (r_state == S_READ) begin
            r_dword <= r_data_mem[w_didx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_ostk_mem[w_sidx] <= w_swd;
        end
        if (r_state == S_READ) begin
            r_top <= r_ostk_mem[w_top_idx];
            r_nxt <= r_ostk_mem[w_nxt_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rwe) begin
            r_rstk_mem[w_rpush_idx] <= r_ip;
        end
        if (r_state == S_READ) begin
            r_ret <= r_rstk_mem[w_ret_idx];
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_next_ip   = r_ip;
    assign o_halted    = r_halted;
    assign o_out_valid = r_ovalid;
    assign o_out_value = r_ovalue;
    assign o_error     = r_err;

endmodule

// ===== design/svie_muldiv.sv =====
// ----------------------------------------------------------------------------
// svie_muldiv: iterative multiply and signed divide unit
// One bit per cycle through a single shared adder, then a final step that
// latches the result and fixes the signs of a division. Division truncates towards zero.
// ----------------------------------------------------------------------------
module svie_muldiv
    import svie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    logic        r_busy;
    logic        r_fix;
    logic [5:0]  r_cnt;
    logic [31:0] r_acc;
    logic [31:0] r_q;
    logic [31:0] r_b;
    logic        r_is_div;
    logic        r_rem;
    logic        r_neg_q;
    logic        r_neg_r;
    logic        r_done;
    logic [31:0] r_res;

    logic [32:0] w_sh;
    logic [32:0] w_sum;
    logic [31:0] w_amag;
    logic [31:0] w_bmag;

    assign w_amag = i_req.a[31] ? (32'd0 - i_req.a) : i_req.a;
    assign w_bmag = i_req.b[31] ? (32'd0 - i_req.b) : i_req.b;

    // The shared adder: trial subtraction for divide, partial sum for multiply.
    assign w_sh  = r_is_div ? {r_acc, r_q[31]} : {1'b0, r_acc};
    assign w_sum = r_is_div ? (w_sh - {1'b0, r_b}) : (w_sh + {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
                r_cnt <= r_cnt + 6'd1;
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_is_div <= i_req.is_div;
            r_rem    <= i_req.want_rem;
            r_neg_q  <= i_req.a[31] ^ i_req.b[31];
            r_neg_r  <= i_req.a[31];
            r_acc    <= 32'd0;
            r_q      <= i_req.is_div ? w_amag : i_req.a;
            r_b      <= i_req.is_div ? w_bmag : i_req.b;
        end else if (r_busy) begin
            if (r_is_div) begin
                if (!w_sum[32]) begin
                    r_acc <= w_sum[31:0];
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_acc <= w_sh[31:0];
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end else begin
                if (r_q[0]) begin
                    r_acc <= w_sum[31:0];
                end
                r_q <= {1'b0, r_q[31:1]};
                r_b <= {r_b[30:0], 1'b0};
            end
        end else if (r_fix) begin
            if (!r_is_div) begin
                r_res <= r_acc;
            end else if (r_rem) begin
                r_res <= r_neg_r ? (32'd0 - r_acc) : r_acc;
            end else begin
                r_res <= r_neg_q ? (32'd0 - r_q) : r_q;
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

// ===== dv/stack_vm_instruction_executor_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_vm_instruction_executor_unit_tb: self-checking bench of the executor
// Drives load and execute requests through the start/busy handshake and
// checks every o_done pulse against a cycle-free predictor of the machine
// state.
// ----------------------------------------------------------------------------
module stack_vm_instruction_executor_unit_tb
    import svie_pkg::*;
();

    // The op field selects an execute when it is not a load.
    localparam logic OP_EXEC = ~OP_LOAD;

    // The packed layout matches the order of the result ports.
    typedef struct packed {
        logic [15:0] next_ip;
        logic        halted;
        logic        out_valid;
        logic [31:0] out_value;
        logic [2:0]  error;
    } t_step_result;

    // One row of the directed table. A row either writes the code length or
    // carries a request, optionally with an expectation typed in by hand.
    typedef struct {
        bit           is_cfg;
        logic         op;
        logic [7:0]   opc;
        logic [15:0]  addr;
        logic [31:0]  val;
        bit           typed;
        t_step_result exp;
    } t_plan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_op;
    logic [7:0]  i_opcode;
    logic [15:0] i_address;
    logic [31:0] i_value;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        o_done;
    logic [15:0] o_next_ip;
    logic        o_halted;
    logic        o_out_valid;
    logic [31:0] o_out_value;
    logic [2:0]  o_error;

    stack_vm_instruction_executor_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_op        (i_op),
        .i_opcode    (i_opcode),
        .i_address   (i_address),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_next_ip   (o_next_ip),
        .o_halted    (o_halted),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_error     (o_error)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Machine state as the predictor sees it. The written flags follow
    // the data store so that the stimulus never reads a word that has
    // never been given a value.
    // ------------------------------------------------------------------
    logic [15:0] vm_code_len;
    logic [15:0] vm_ip;
    logic [31:0] vm_data     [DATA_DEPTH];
    bit          vm_written  [DATA_DEPTH];
    logic [31:0] vm_operands [STACK_DEPTH];
    int          vm_opcount;
    logic [15:0] vm_returns  [STACK_DEPTH];
    int          vm_retcount;

    t_step_result expected_results[$];
    int           sender_idle_pct;
    int           requests;
    int           directed_requests;
    int           results_seen;
    int           mismatches;
    int           errors_seen [8];

    // Works out the result of one request and advances the predicted state.
    // An instruction that fails leaves every piece of state as it was, so
    // stack and memory updates are made only on the success paths.
    function automatic t_step_result execute_step(input logic op, input logic [7:0] opc,
                                                  input logic [15:0] addr,
                                                  input logic [31:0] val);
        t_step_result r;
        logic         mem_ok;
        logic         uses_mem;
        logic [31:0]  ua;
        logic [31:0]  ub;
        logic [31:0]  tmp;
        longint       a;
        longint       b;

        r          = '0;
        r.next_ip  = vm_ip;
        r.error    = ERR_NONE;
        mem_ok     = addr < DATA_DEPTH;
        uses_mem   = opc == OPC_PUSH || opc == OPC_POP ||
                     ((opc == OPC_INC || opc == OPC_DEC || opc == OPC_NOT) && addr != 0);

        if (op == OP_LOAD) begin
            if (mem_ok) begin
                vm_data[addr[DAW-1:0]]    = val;
                vm_written[addr[DAW-1:0]] = 1'b1;
            end else begin
                r.error = ERR_ADDR;
            end
        end else if (vm_ip >= vm_code_len) begin
            r.error = ERR_IP;
        end else if (opc > OPC_HALT) begin
            r.error = ERR_OPC;
        end else if (uses_mem && !mem_ok) begin
            r.error = ERR_ADDR;
        end else begin
            r.next_ip = vm_ip + 16'd1;
            case (opc)
                OPC_NOP: ;
                OPC_PUSH: begin
                    if (vm_opcount >= STACK_DEPTH) r.error = ERR_OVER;
                    else vm_operands[vm_opcount++] = vm_data[addr[DAW-1:0]];
                end
                OPC_POP: begin
                    if (vm_opcount == 0) begin
                        r.error = ERR_UNDER;
                    end else begin
                        vm_data[addr[DAW-1:0]]    = vm_operands[--vm_opcount];
                        vm_written[addr[DAW-1:0]] = 1'b1;
                    end
                end
                OPC_JMP: r.next_ip = addr;
                OPC_JZ, OPC_CZ: begin
                    if (vm_opcount == 0) begin
                        r.error = ERR_UNDER;
                    end else if (vm_operands[vm_opcount - 1] != 0) begin
                        vm_opcount--;
                    end else if (opc == OPC_CZ && vm_retcount >= STACK_DEPTH) begin
                        r.error = ERR_OVER;
                    end else begin
                        vm_opcount--;
                        if (opc == OPC_CZ) vm_returns[vm_retcount++] = vm_ip;
                        r.next_ip = addr;
                    end
                end
                OPC_CALL: begin
                    if (vm_retcount >= STACK_DEPTH) begin
                        r.error = ERR_OVER;
                    end else begin
                        vm_returns[vm_retcount++] = vm_ip;
                        r.next_ip = addr;
                    end
                end
                OPC_RET: begin
                    if (vm_retcount == 0) r.error = ERR_UNDER;
                    else r.next_ip = vm_returns[--vm_retcount] + 16'd1;
                end
                OPC_INC, OPC_DEC, OPC_NOT: begin
                    if (addr == 0 && vm_opcount == 0) begin
                        r.error = ERR_UNDER;
                    end else begin
                        tmp = (addr != 0) ? vm_data[addr[DAW-1:0]]
                                          : vm_operands[vm_opcount - 1];
                        if (opc == OPC_INC) tmp = tmp + 32'd1;
                        else if (opc == OPC_DEC) tmp = tmp - 32'd1;
                        else tmp = (tmp == 0) ? 32'd1 : 32'd0;
                        if (addr != 0) vm_data[addr[DAW-1:0]] = tmp;
                        else vm_operands[vm_opcount - 1] = tmp;
                    end
                end
                OPC_IN: begin
                    if (vm_opcount >= STACK_DEPTH) r.error = ERR_OVER;
                    else vm_operands[vm_opcount++] = val;
                end
                OPC_OUT: begin
                    if (vm_opcount == 0) begin
                        r.error = ERR_UNDER;
                    end else begin
                        r.out_valid = 1'b1;
                        r.out_value = vm_operands[--vm_opcount];
                    end
                end
                OPC_HALT: begin
                    r.halted  = 1'b1;
                    r.next_ip = vm_ip;
                end
                default: begin
                    // Binary operations: b is the top, a the entry below it.
                    // Working in 64 bits keeps the most negative value over
                    // minus one well defined; truncation then wraps it.
                    if (vm_opcount < 2) begin
                        r.error = ERR_UNDER;
                    end else begin
                        ub = vm_operands[vm_opcount - 1];
                        ua = vm_operands[vm_opcount - 2];
                        a  = $signed(ua);
                        b  = $signed(ub);
                        if ((opc == OPC_DIV || opc == OPC_MOD) && ub == 0) begin
                            r.error = ERR_DIV0;
                        end else begin
                            case (opc)
                                OPC_ADD: tmp = ua + ub;
                                OPC_SUB: tmp = ua - ub;
                                OPC_MUL: tmp = ua * ub;
                                OPC_DIV: tmp = 32'(a / b);
                                OPC_MOD: tmp = 32'(a % b);
                                OPC_GT:  tmp = (a > b) ? 32'd1 : 32'd0;
                                OPC_LT:  tmp = (a < b) ? 32'd1 : 32'd0;
                                OPC_EQ:  tmp = (ua == ub) ? 32'd1 : 32'd0;
                                OPC_AND: tmp = (ua != 0 && ub != 0) ? 32'd1 : 32'd0;
                                default: tmp = (ua != 0 || ub != 0) ? 32'd1 : 32'd0;
                            endcase
                            vm_opcount--;
                            vm_operands[vm_opcount - 1] = tmp;
                        end
                    end
                end
            endcase
            if (r.error != ERR_NONE) r.next_ip = vm_ip;
        end

        vm_ip = r.next_ip;
        return r;
    endfunction

    // Presents one request, after a random number of idle cycles, and
    // records its expected result once the block has taken it. Inputs only
    // change on the falling edge; acceptance is judged on the rising edge.
    task automatic send_request(input logic op, input logic [7:0] opc,
                                input logic [15:0] addr, input logic [31:0] val,
                                input bit typed = 1'b0,
                                input t_step_result typed_exp = '0);
        t_step_result pred;

        while ($urandom_range(0, 99) < sender_idle_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start   <= 1'b1;
        i_op      <= op;
        i_opcode  <= opc;
        i_address <= addr;
        i_value   <= val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pred = execute_step(op, opc, addr, val);
        expected_results.push_back(typed ? typed_exp : pred);
        requests++;
    endtask

    // The code length may only change while nothing is in flight. Every
    // request gives a result, so an empty queue means the block is idle;
    // a few spare cycles are left all the same.
    task automatic write_code_length(input logic [15:0] len);
        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        vm_code_len = len;
    endtask

    // Random request, shaped so that most instructions find a usable stack
    // and in-range jump targets, with loads and bad opcodes mixed in.
    task automatic random_request();
        int          pick;
        int          top;
        logic [7:0]  opc;
        logic [15:0] addr;
        logic [31:0] val;

        pick = $urandom_range(0, 99);
        val  = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: val = 32'h8000_0000;
                1: val = 32'h7fff_ffff;
                2: val = 32'hffff_ffff;
                default: val = 32'd0;
            endcase
        end
        // Jump targets stay well clear of the top of the ip range, from
        // which the machine could never leave again.
        top = (vm_code_len > 1) ? vm_code_len - 1 : 0;
        if (top > 60000) top = 60000;

        if (pick < 8) begin
            addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
            send_request(OP_LOAD, 8'($urandom), addr, val);
        end else if (pick < 12) begin
            send_request(OP_EXEC, 8'($urandom_range(OPC_HALT + 1, 255)), 16'($urandom), val);
        end else begin
            opc  = 8'($urandom_range(0, OPC_HALT));
            if (vm_opcount < 2 && $urandom_range(0, 1) == 1) opc = OPC_IN;
            addr = 16'($urandom_range(0, 63));
            case (opc)
                OPC_JMP, OPC_JZ, OPC_CALL, OPC_CZ: addr = 16'($urandom_range(0, top));
                OPC_INC, OPC_DEC, OPC_NOT: if ($urandom_range(0, 1) == 1) addr = '0;
                OPC_PUSH, OPC_POP: begin
                    if ($urandom_range(0, 15) == 0)
                        addr = 16'($urandom_range(DATA_DEPTH, 65535));
                end
                default: ;
            endcase
            // A read of a word that has never been loaded becomes the load.
            if ((opc == OPC_PUSH || ((opc == OPC_INC || opc == OPC_DEC || opc == OPC_NOT)
                    && addr != 0)) && addr < DATA_DEPTH && !vm_written[addr[DAW-1:0]])
                send_request(OP_LOAD, opc, addr, val);
            else
                send_request(OP_EXEC, opc, addr, val);
        end
    endtask

    task automatic report_mismatch(input string what, input t_step_result exp,
                                   input t_step_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $write("%0t: %s: expected ip %0d halt %0b out %0b/%h err %0d, ",
                   $time, what, exp.next_ip, exp.halted, exp.out_valid, exp.out_value,
                   exp.error);
            $display("got ip %0d halt %0b out %0b/%h err %0d",
                     got.next_ip, got.halted, got.out_valid, got.out_value, got.error);
        end
    endtask

    // Result checker: every o_done pulse is matched to the oldest request.
    always @(posedge i_clk) begin
        t_step_result got;
        t_step_result exp;
        if (i_rst_n && o_done) begin
            got = {o_next_ip, o_halted, o_out_valid, o_out_value, o_error};
            results_seen++;
            errors_seen[got.error]++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no request waiting", '0, got);
            end else begin
                exp = expected_results.pop_front();
                if (got !== exp) report_mismatch("result mismatch", exp, got);
            end
        end
    end

    // Directed table rows.
    function automatic t_plan_row load_row(input logic [15:0] addr, input logic [31:0] val);
        t_plan_row row;
        row = '{is_cfg: 1'b0, op: OP_LOAD, opc: '0, addr: addr, val: val,
                typed: 1'b0, exp: '0};
        return row;
    endfunction

    function automatic t_plan_row exec_row(input logic [7:0] opc, input logic [15:0] addr,
                                           input logic [31:0] val);
        t_plan_row row;
        row = '{is_cfg: 1'b0, op: OP_EXEC, opc: opc, addr: addr, val: val,
                typed: 1'b0, exp: '0};
        return row;
    endfunction

    // A row whose result is plain from the state: a stalled ip and an error.
    function automatic t_plan_row typed_row(input t_plan_row row, input logic [15:0] ip,
                                            input logic [2:0] err);
        row.typed       = 1'b1;
        row.exp         = '0;
        row.exp.next_ip = ip;
        row.exp.error   = err;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(input logic [15:0] len);
        t_plan_row row;
        row = '{is_cfg: 1'b1, op: OP_LOAD, opc: '0, addr: '0, val: {16'd0, len},
                typed: 1'b0, exp: '0};
        return row;
    endfunction

    initial begin
        t_plan_row plan[$];

        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_op            = OP_LOAD;
        i_opcode        = '0;
        i_address       = '0;
        i_value         = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        vm_code_len     = '0;
        vm_ip           = '0;
        vm_opcount      = 0;
        vm_retcount     = 0;
        sender_idle_pct = 16;
        requests        = 0;
        results_seen    = 0;
        mismatches      = 0;
        foreach (vm_written[i]) vm_written[i] = 1'b0;
        foreach (errors_seen[i]) errors_seen[i] = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The code length is zero out of reset, so the first
        // execute must stall on the end of the code.
        plan.push_back(typed_row(exec_row(OPC_NOP, 16'd0, 32'd0), 16'd0, ERR_IP));
        plan.push_back(typed_row(load_row(16'hffff, 32'h1234_5678), 16'd0, ERR_ADDR));
        plan.push_back(load_row(16'd0, 32'h7fff_ffff));
        plan.push_back(load_row(16'd1, 32'h8000_0000));
        plan.push_back(load_row(16'd4095, 32'hffff_ffff));
        plan.push_back(cfg_row(16'hffff));
        plan.push_back(typed_row(exec_row(8'hff, 16'd0, 32'd0), 16'd0, ERR_OPC));
        plan.push_back(typed_row(exec_row(OPC_POP, 16'd2, 32'd0), 16'd0, ERR_UNDER));
        plan.push_back(typed_row(exec_row(OPC_PUSH, 16'd4096, 32'd0), 16'd0, ERR_ADDR));
        plan.push_back(typed_row(exec_row(OPC_OUT, 16'd0, 32'd0), 16'd0, ERR_UNDER));
        plan.push_back(typed_row(exec_row(OPC_RET, 16'd0, 32'd0), 16'd0, ERR_UNDER));
        // Most negative value over minus one, then a zero divisor.
        plan.push_back(exec_row(OPC_PUSH, 16'd1, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'hffff_ffff));
        plan.push_back(exec_row(OPC_DIV, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_MOD, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_PUSH, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_ADD, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_MUL, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_INC, 16'd4095, 32'd0));
        plan.push_back(exec_row(OPC_PUSH, 16'd4095, 32'd0));
        plan.push_back(exec_row(OPC_SUB, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_DEC, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_NOT, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'h7fff_ffff));
        plan.push_back(exec_row(OPC_GT, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'h8000_0000));
        plan.push_back(exec_row(OPC_LT, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_EQ, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'd7));
        plan.push_back(exec_row(OPC_AND, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_OR, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_JZ, 16'd100, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_CZ, 16'd300, 32'd0));
        plan.push_back(exec_row(OPC_CALL, 16'd500, 32'd0));
        plan.push_back(exec_row(OPC_RET, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_RET, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_NOT, 16'd4095, 32'd0));
        plan.push_back(exec_row(OPC_POP, 16'd3, 32'd0));
        plan.push_back(exec_row(OPC_JMP, 16'd40000, 32'd0));
        plan.push_back(exec_row(OPC_HALT, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_NOP, 16'd0, 32'd0));
        plan.push_back(exec_row(OPC_IN, 16'd0, 32'h5a5a_a5a5));
        plan.push_back(exec_row(OPC_OUT, 16'd0, 32'd0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_code_length(plan[i].val[15:0]);
            else
                send_request(plan[i].op, plan[i].opc, plan[i].addr, plan[i].val,
                             plan[i].typed, plan[i].exp);
        end
        directed_requests = requests;

        // First phase: full code length, the sender idles now and then.
        // Both stacks are driven past their limits in each direction.
        write_code_length(16'hffff);
        repeat (60) random_request();
        repeat (STACK_DEPTH + 2) send_request(OP_EXEC, OPC_IN, 16'd0, $urandom);
        repeat (STACK_DEPTH + 4) send_request(OP_EXEC, OPC_OUT, 16'd0, 32'd0);
        repeat (STACK_DEPTH + 2) send_request(OP_EXEC, OPC_CALL, vm_ip, 32'd0);
        repeat (STACK_DEPTH + 4) send_request(OP_EXEC, OPC_RET, 16'd0, 32'd0);
        repeat (60) random_request();

        // Second phase: a mid-range code length and a sender that is mostly
        // idle. The ip can run past the end, which the last phase
        // recovers from by widening the code again.
        sender_idle_pct = 88;
        write_code_length(16'($urandom_range(1000, 4000)));
        repeat (120) random_request();

        // An empty program stalls every execute.
        sender_idle_pct = 0;
        write_code_length(16'd0);
        repeat (10) random_request();

        // Last phase: back-to-back requests over the full code length.
        write_code_length(16'hffff);
        repeat (120) random_request();

        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d requests (%0d directed) over code lengths 0, mid-range and 65535;",
                 requests, directed_requests);
        $display("checked %0d results: %0d clean, errors under %0d over %0d div0 %0d,",
                 results_seen, errors_seen[ERR_NONE], errors_seen[ERR_UNDER],
                 errors_seen[ERR_OVER], errors_seen[ERR_DIV0]);
        $display("opc %0d addr %0d ip %0d.", errors_seen[ERR_OPC],
                 errors_seen[ERR_ADDR], errors_seen[ERR_IP]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
